// ----- rtl/long_press_sleep_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Long-press sleep controller assertion macros
// Implication checks on the rising clock edge, off while reset is high.
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_SLEEP_CONTROLLER_ASSERT_SVH
`define LONG_PRESS_SLEEP_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define LPSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpsc same-cycle check failed");

`define LPSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpsc next-cycle check failed");

`else

`define LPSC_ASSERT_SAME(label, clk, rst, ante, cons)

`define LPSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/lpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpsc_pkg
// Types and constants shared by the long-press sleep controller.
// ----------------------------------------------------------------------------
package lpsc_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int TIMER_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [TIMER_WIDTH-1:0] HOLD_TICKS_RESET = TIMER_WIDTH'(2000);
   localparam logic [TIMER_WIDTH-1:0] RELEASE_DEBOUNCE_RESET = TIMER_WIDTH'(50);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HOLD_TICKS       = 1'b0,
      CSR_RELEASE_DEBOUNCE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_WAIT_RELEASE = 3'd0,
      PH_IDLE         = 3'd1,
      PH_HOLDING      = 3'd2,
      PH_DEBOUNCE     = 3'd3,
      PH_ASLEEP       = 3'd4
   } phase_type;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_BOOT = 1'b1;

   typedef struct packed {
      logic command;
      logic button_pressed;
      logic woke_by_button;
      logic wake_arm_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]             phase;
      logic                   sleep_request;
      logic                   arm_failed;
      logic [COUNT_WIDTH-1:0] sleep_entries;
      logic [COUNT_WIDTH-1:0] button_wakes;
   } rsp_type;

   typedef struct packed {
      logic [TIMER_WIDTH-1:0] hold_ticks;
      logic [TIMER_WIDTH-1:0] release_debounce_ticks;
   } cfg_type;

   function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
      sat_inc = (v == {TIMER_WIDTH{1'b1}}) ? v : v + TIMER_WIDTH'(1);
   endfunction

endpackage

// ----- rtl/lpsc_in_stage.sv -----
// ----------------------------------------------------------------------------
// lpsc_in_stage
// Input register: holds one request word until the core takes it.
// ----------------------------------------------------------------------------
module lpsc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpsc_pkg::req_type req_data,
   input  logic             take,
   output logic             item_valid,
   output lpsc_pkg::req_type item_data
);
   import lpsc_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff, in_data_in;
   logic    load;

   assign load = !in_vld_ff || take;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      if (load) begin
         in_vld_in  = req_valid;
         in_data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   assign req_stall  = !load;
   assign item_valid = in_vld_ff;
   assign item_data  = in_data_ff;

endmodule

// ----- rtl/lpsc_core.sv -----
// ----------------------------------------------------------------------------
// lpsc_core
// Phase machine, hold and release timers, entry and wake counters.
// ----------------------------------------------------------------------------
module lpsc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  lpsc_pkg::req_type item,
   input  lpsc_pkg::cfg_type cfg,
   output lpsc_pkg::rsp_type result
);
   import lpsc_pkg::*;

   phase_type              mode_ff, mode_in;
   logic [TIMER_WIDTH-1:0] held_ff, held_in;
   logic [TIMER_WIDTH-1:0] stable_ff, stable_in;
   logic [COUNT_WIDTH-1:0] entry_ff, entry_in;
   logic [COUNT_WIDTH-1:0] wake_ff, wake_in;
   logic [TIMER_WIDTH-1:0] held_inc;
   logic [TIMER_WIDTH-1:0] stable_nxt;
   logic                   sleep_req;
   logic                   arm_fail;

   assign held_inc   = sat_inc(held_ff);
   assign stable_nxt = item.button_pressed ? '0 : sat_inc(stable_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= PH_IDLE;
         held_ff   <= '0;
         stable_ff <= '0;
         entry_ff  <= '0;
         wake_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         stable_ff <= stable_in;
         entry_ff  <= entry_in;
         wake_ff   <= wake_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      stable_in = stable_ff;
      entry_in  = entry_ff;
      wake_in   = wake_ff;
      sleep_req = 1'b0;
      arm_fail  = 1'b0;
      if (advance) begin
         if (item.command == CMD_BOOT) begin
            mode_in   = item.button_pressed ? PH_WAIT_RELEASE : PH_IDLE;
            held_in   = '0;
            stable_in = '0;
            if (item.woke_by_button) begin
               wake_in = wake_ff + COUNT_WIDTH'(1);
            end
         end else begin
            unique case (mode_ff)
               PH_WAIT_RELEASE: begin
                  if (!item.button_pressed) begin
                     mode_in = PH_IDLE;
                  end
               end
               PH_IDLE: begin
                  if (item.button_pressed) begin
                     mode_in = PH_HOLDING;
                     held_in = '0;
                  end
               end
               PH_HOLDING: begin
                  if (!item.button_pressed) begin
                     mode_in = PH_IDLE;
                  end else begin
                     held_in = held_inc;
                     if (held_inc >= cfg.hold_ticks) begin
                        mode_in   = PH_DEBOUNCE;
                        stable_in = '0;
                     end
                  end
               end
               PH_DEBOUNCE: begin
                  stable_in = stable_nxt;
                  if (stable_nxt >= cfg.release_debounce_ticks) begin
                     if (item.wake_arm_ok) begin
                        entry_in  = entry_ff + COUNT_WIDTH'(1);
                        sleep_req = 1'b1;
                        mode_in   = PH_ASLEEP;
                     end else begin
                        arm_fail = 1'b1;
                        mode_in  = PH_WAIT_RELEASE;
                     end
                  end
               end
               PH_ASLEEP: begin
               end
               default: begin
                  mode_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   assign result.phase         = mode_in;
   assign result.sleep_request = sleep_req;
   assign result.arm_failed    = arm_fail;
   assign result.sleep_entries = entry_in;
   assign result.button_wakes  = wake_in;

endmodule

// ----- rtl/lpsc_out_stage.sv -----
// ----------------------------------------------------------------------------
// lpsc_out_stage
// Result register: holds one response word until the consumer takes it.
// ----------------------------------------------------------------------------
module lpsc_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  lpsc_pkg::rsp_type result,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpsc_pkg::rsp_type rsp_data
);
   import lpsc_pkg::*;

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign ready = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/long_press_sleep_controller.sv -----
// ----------------------------------------------------------------------------
// long_press_sleep_controller
// Power-button long-press detector with release debounce and sleep arming.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   lpsc_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall   lpsc_pkg::rsp_type
//   csr      in         csr_we                csr_index, csr_wdata
//
// One word per cycle while rsp is not stalled; each word passes from req to rsp
// through the input register, then phase logic into the result register.
// Synchronous active-high reset: empty stages, phase idle, timers and
// counters zero, registers at 2000 and 50.
// A stalled rsp word holds the input register; req stalls only then.
// ----------------------------------------------------------------------------
`include "long_press_sleep_controller_assert.svh"

module long_press_sleep_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lpsc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lpsc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [lpsc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lpsc_pkg::TIMER_WIDTH-1:0]      csr_wdata
);
   import lpsc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    item_valid;
   req_type item_data;
   rsp_type result;
   logic    out_ready;
   logic    advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HOLD_TICKS:       cfg_in.hold_ticks             = csr_wdata;
            CSR_RELEASE_DEBOUNCE: cfg_in.release_debounce_ticks = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks             <= HOLD_TICKS_RESET;
         cfg_ff.release_debounce_ticks <= RELEASE_DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance = item_valid && out_ready;

   lpsc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   lpsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_data),
      .cfg     (cfg_ff),
      .result  (result)
   );

   lpsc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `LPSC_ASSERT_SAME(a_req_pulse_phase, clock, reset, rsp_valid && rsp_data.sleep_request, rsp_data.phase == PH_ASLEEP && !rsp_data.arm_failed)
   `LPSC_ASSERT_SAME(a_fail_phase, clock, reset, rsp_valid && rsp_data.arm_failed, rsp_data.phase == PH_WAIT_RELEASE)
   `LPSC_ASSERT_NEXT(a_advance_lands, clock, reset, advance, rsp_valid)
   `LPSC_ASSERT_SAME(a_stall_only_full, clock, reset, req_stall, item_valid && !out_ready)

endmodule

// ----- sim/tb_long_press_sleep_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_long_press_sleep_controller
// Self-checking bench for the long-press sleep controller. A status tracker
// follows every accepted button word and queues the status word it implies;
// each status word leaving the block is compared field by field, in order.
// Directed runs cover boot cases, reset and zero timer settings and the
// largest timer settings; random runs press, bounce and arm with both sides
// idling at random, except in one calm run with no idling.
// ----------------------------------------------------------------------------
module tb_long_press_sleep_controller;
   import lpsc_pkg::*;

   localparam int CYCLE_LIMIT = 50_000;

   class status_tracker;
      phase_type               mode;
      logic [TIMER_WIDTH-1:0]  hold_limit;
      logic [TIMER_WIDTH-1:0]  release_limit;
      logic [TIMER_WIDTH-1:0]  held;
      logic [TIMER_WIDTH-1:0]  released;
      logic [COUNT_WIDTH-1:0]  entries;
      logic [COUNT_WIDTH-1:0]  wakes;
      int                      arm_fails;
      int                      checked;
      int                      mismatches;
      rsp_type                 status_due[$];

      function new();
         mode          = PH_IDLE;
         hold_limit    = HOLD_TICKS_RESET;
         release_limit = RELEASE_DEBOUNCE_RESET;
         held          = '0;
         released      = '0;
         entries       = '0;
         wakes         = '0;
         arm_fails     = 0;
         checked       = 0;
         mismatches    = 0;
      endfunction

      function logic [TIMER_WIDTH-1:0] bump(logic [TIMER_WIDTH-1:0] v);
         return (v == {TIMER_WIDTH{1'b1}}) ? v : v + TIMER_WIDTH'(1);
      endfunction

      function void take_button_word(req_type w);
         rsp_type want;
         logic    go_sleep;
         logic    arm_bad;
         go_sleep = 1'b0;
         arm_bad  = 1'b0;
         if (w.command == CMD_BOOT) begin
            if (w.button_pressed) mode = PH_WAIT_RELEASE;
            else mode = PH_IDLE;
            held     = '0;
            released = '0;
            if (w.woke_by_button) wakes = wakes + COUNT_WIDTH'(1);
         end else begin
            case (mode)
               PH_WAIT_RELEASE: begin
                  if (!w.button_pressed) mode = PH_IDLE;
               end
               PH_IDLE: begin
                  if (w.button_pressed) begin
                     mode = PH_HOLDING;
                     held = '0;
                  end
               end
               PH_HOLDING: begin
                  if (!w.button_pressed) begin
                     mode = PH_IDLE;
                  end else begin
                     held = bump(held);
                     if (held >= hold_limit) begin
                        mode     = PH_DEBOUNCE;
                        released = '0;
                     end
                  end
               end
               PH_DEBOUNCE: begin
                  if (w.button_pressed) released = '0;
                  else released = bump(released);
                  if (released >= release_limit) begin
                     if (w.wake_arm_ok) begin
                        entries  = entries + COUNT_WIDTH'(1);
                        go_sleep = 1'b1;
                        mode     = PH_ASLEEP;
                     end else begin
                        arm_bad = 1'b1;
                        mode    = PH_WAIT_RELEASE;
                        arm_fails++;
                     end
                  end
               end
               default: ;
            endcase
         end
         want.phase         = mode;
         want.sleep_request = go_sleep;
         want.arm_failed    = arm_bad;
         want.sleep_entries = entries;
         want.button_wakes  = wakes;
         status_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_status_word(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            $display("%0t: status word %h with none expected", $time, got);
            mismatches++;
            return;
         end
         want = status_due.pop_front();
         checked++;
         compare_field("phase", 32'(want.phase), 32'(got.phase));
         compare_field("sleep_request", 32'(want.sleep_request), 32'(got.sleep_request));
         compare_field("arm_failed", 32'(want.arm_failed), 32'(got.arm_failed));
         compare_field("sleep_entries", 32'(want.sleep_entries), 32'(got.sleep_entries));
         compare_field("button_wakes", 32'(want.button_wakes), 32'(got.button_wakes));
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   req_type                     req_data;
   logic                        rsp_valid;
   logic                        rsp_stall;
   rsp_type                     rsp_data;
   logic                        csr_we;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [TIMER_WIDTH-1:0]      csr_wdata;

   status_tracker board;
   logic          calm = 1'b0;
   int            words_sent = 0;
   int            settings = 0;
   int            cycles = 0;

   long_press_sleep_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_status_word(rsp_data);
         rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
      end
   end

   task automatic send_word(req_type w);
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_button_word(w);
      words_sent++;
   endtask

   task automatic tick(logic pressed, logic arm_ok);
      req_type w;
      w.command        = CMD_TICK;
      w.button_pressed = pressed;
      w.woke_by_button = 1'($urandom_range(0, 1));
      w.wake_arm_ok    = arm_ok;
      send_word(w);
   endtask

   task automatic boot(logic pressed, logic woke);
      req_type w;
      w.command        = CMD_BOOT;
      w.button_pressed = pressed;
      w.woke_by_button = woke;
      w.wake_arm_ok    = 1'($urandom_range(0, 1));
      send_word(w);
   endtask

   // block empty before any register write and at the end
   task automatic drain(int extra);
      req_valid <= 1'b0;
      while (board.status_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic configure(logic [TIMER_WIDTH-1:0] hold, logic [TIMER_WIDTH-1:0] deb);
      drain(4);
      csr_we    <= 1'b1;
      csr_index <= CSR_HOLD_TICKS;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_RELEASE_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_we <= 1'b0;
      board.hold_limit    = hold;
      board.release_limit = deb;
      settings++;
   endtask

   // idle, long press (sometimes cut short), bouncy release, arming
   task automatic press_cycle();
      int need;
      int presses;
      if (board.mode == PH_WAIT_RELEASE) tick(1'b0, 1'($urandom_range(0, 1)));
      else if (board.mode != PH_IDLE) boot(1'b0, 1'($urandom_range(0, 1)));
      need    = (board.hold_limit == 0) ? 2 : int'(board.hold_limit) + 1;
      presses = ($urandom_range(0, 99) < 20) ? int'($urandom_range(1, need - 1)) : need;
      repeat (presses) tick(1'b1, 1'($urandom_range(0, 1)));
      if (board.mode != PH_DEBOUNCE) begin
         tick(1'b0, 1'($urandom_range(0, 1)));
         return;
      end
      while (board.mode == PH_DEBOUNCE)
         tick($urandom_range(0, 99) < 15, $urandom_range(0, 99) < 75);
      repeat ($urandom_range(0, 2))
         tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_phase(int budget);
      int         first;
      int         pick;
      logic [3:0] noise;
      first = words_sent;
      while (words_sent - first < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            press_cycle();
         end else if (pick < 80) begin
            boot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               noise = 4'($urandom);
               send_word(noise);
            end
         end
      end
   endtask

   initial begin
      board = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_HOLD_TICKS;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset timer values; boot cases, a press well short of the hold time
      tick(1'b0, 1'b1);
      boot(1'b0, 1'b0);
      boot(1'b0, 1'b1);
      boot(1'b1, 1'b1);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b0);
      repeat (40) tick(1'b1, 1'($urandom_range(0, 1)));
      tick(1'b0, 1'b1);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b1);
      boot(1'b0, 1'b1);

      // zero timers: second pressed tick triggers, arming on first debounce tick
      configure('0, '0);
      tick(1'b1, 1'b1);
      tick(1'b1, 1'b1);
      tick(1'b1, 1'b0);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b1);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b1);
      tick(1'b1, 1'b0);
      tick(1'b1, 1'b0);
      tick(1'b1, 1'b1);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b0);
      boot(1'b1, 1'b0);
      boot(1'b1, 1'b1);

      // largest timers: a long press stays in holding
      configure('1, '1);
      boot(1'b0, 1'b0);
      repeat (40) tick(1'b1, 1'($urandom_range(0, 1)));
      tick(1'b0, 1'b1);
      boot(1'b0, 1'b1);

      for (int i = 0; i < 4; i++) begin
         if (i == 0) configure(16'd1, 16'd1);
         else configure(TIMER_WIDTH'($urandom_range(0, 10)),
                        TIMER_WIDTH'($urandom_range(0, 10)));
         calm = (i == 2);
         random_phase(85);
         calm = 1'b0;
      end

      drain(8);
      $display("Checked %0d status words from %0d button words over %0d timer settings",
               board.checked, words_sent, settings);
      $display("Predicted %0d sleep entries, %0d failed arming attempts, %0d button wakes",
               board.entries, board.arm_fails, board.wakes);
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lpsc_pkg.sv
rtl/lpsc_in_stage.sv
rtl/lpsc_core.sv
rtl/lpsc_out_stage.sv
rtl/long_press_sleep_controller.sv
sim/tb_long_press_sleep_controller.sv
